### src/srsw_pkg.sv
// Shared types and constants of the selective-repeat send window.
package srsw_pkg;

	localparam int WINDOW_DEF      = 16;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int MAX_PAYLOAD     = 1024;
	localparam int MAX_RESULTS     = 32;
	localparam int RES_W           = $clog2(MAX_RESULTS + 1);
	localparam int CMDQ_DEPTH      = 2;
	localparam int OUTQ_DEPTH      = 4;

	localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [1:0] REG_QUEUE_LIMIT = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_ACK  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NEW     = 2'd0,
		KIND_RESEND  = 2'd1,
		KIND_REFUSED = 2'd2
	} kind_t;

	typedef struct packed {
		mode_t       mode;
		logic [10:0] size;
		logic [15:0] ack;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] seq;
		logic [10:0] size;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [4:0]  window_size;
		logic [6:0]  queue_limit;
		logic [15:0] timeout_ms;
	} cfg_t;

endpackage

### src/srsw_front.sv
// Front: accepts input words, saturates the size and queues commands.
module srsw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           mode,
	input  logic [10:0]          seg_size,
	input  logic [15:0]          ack_seq,
	input  logic [31:0]          now_ms,
	output logic                 cmd_empty,
	input  logic                 cmd_pop,
	output srsw_pkg::cmd_t       cmd
);
	import srsw_pkg::*;

	localparam int PW = $clog2(CMDQ_DEPTH);

	cmd_t          mem_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	cmd_t          in_cmd;
	logic          wr_en, rd_en;

	always_comb begin
		in_cmd.mode = mode_t'(mode);
		in_cmd.size = ({6'd0, seg_size} > 17'(MAX_PAYLOAD)) ? 11'(MAX_PAYLOAD) : seg_size;
		in_cmd.ack  = ack_seq;
		in_cmd.now  = now_ms;
	end

	assign full      = (cnt_q == (PW+1)'(CMDQ_DEPTH));
	assign cmd_empty = (cnt_q == '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && !cmd_empty;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PW'(CMDQ_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == PW'(CMDQ_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

endmodule

### src/srsw_out_q.sv
// Result queue between the engine and the result ports.
module srsw_out_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_push,
	input  srsw_pkg::res_t  res_in,
	output logic            res_full,
	output logic            empty,
	input  logic            pop,
	output srsw_pkg::res_t  res_out
);
	import srsw_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);

	res_t          mem_q [OUTQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          wr_en, rd_en;

	assign res_full = (cnt_q == (PW+1)'(OUTQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;
	assign res_out  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PW'(OUTQ_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == PW'(OUTQ_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result queue overflow");

endmodule

### src/srsw_engine.sv
// Back end: window state, pending FIFO, resend scan and send sequencer.
module srsw_engine #(
	parameter int WINDOW      = srsw_pkg::WINDOW_DEF,
	parameter int QUEUE_DEPTH = srsw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  srsw_pkg::cfg_t  cfg,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  srsw_pkg::cmd_t  cmd,
	output logic            res_push,
	output srsw_pkg::res_t  res_word,
	input  logic            res_full
);
	import srsw_pkg::*;

	localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int IW   = $clog2(WINDOW + 1);
	localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_ENQ   = 9'b000000010,
		ST_ACK   = 9'b000000100,
		ST_ASCAN = 9'b000001000,
		ST_TRD   = 9'b000010000,
		ST_TCHK  = 9'b000100000,
		ST_SRD   = 9'b001000000,
		ST_SEMIT = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [15:0]     base_q, next_q;
	logic [SW-1:0]   base_slot_q, next_slot_q, scan_slot_q;
	logic [WINDOW-1:0] valid_q;
	logic [QW-1:0]   head_q, tail_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   i_q;
	logic [RES_W-1:0] n_q;
	logic            hold_valid_q;
	res_t            hold_q;

	logic [10:0]     pend_mem [QUEUE_DEPTH];
	logic [10:0]     pend_rd_q;
	logic [42:0]     win_mem [WINDOW];
	logic [42:0]     win_rd_q;

	logic [15:0]     span, d_ack;
	logic [15:0]     win_eff;
	logic [SW:0]     ack_sum;
	logic [SW-1:0]   ack_slot, scan_inc, next_inc;
	logic            emit_ok, emit_fire, expired, enq_ok, send_ok, scan_more;
	logic [31:0]     age;
	res_t            emit_word;
	logic            pend_we, win_we;
	logic [42:0]     win_wdata;
	logic [SW-1:0]   win_waddr;

	assign span     = next_q - base_q;
	assign d_ack    = cmd_q.ack - base_q;
	assign win_eff  = (16'(cfg.window_size) > 16'(WINDOW)) ? 16'(WINDOW) : 16'(cfg.window_size);
	assign ack_sum  = (SW+1)'(base_slot_q) + (SW+1)'(d_ack[SW-1:0]);
	assign ack_slot = (ack_sum >= (SW+1)'(WINDOW)) ? SW'(ack_sum - (SW+1)'(WINDOW))
		: ack_sum[SW-1:0];
	assign scan_inc = (scan_slot_q == SW'(WINDOW-1)) ? '0 : scan_slot_q + 1'b1;
	assign next_inc = (next_slot_q == SW'(WINDOW-1)) ? '0 : next_slot_q + 1'b1;
	assign age      = cmd_q.now - win_rd_q[31:0];
	assign expired  = valid_q[scan_slot_q] && (age > 32'(cfg.timeout_ms));
	assign enq_ok   = (CMPW'(count_q) <= CMPW'(cfg.queue_limit))
		&& (count_q < CW'(QUEUE_DEPTH));
	assign send_ok  = (span < win_eff) && (count_q != '0) && (n_q < RES_W'(MAX_RESULTS));
	assign scan_more = 16'(i_q) < span;
	assign emit_ok  = !hold_valid_q || !res_full;
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;

	always_comb begin
		emit_fire = 1'b0;
		emit_word = '0;
		pend_we   = 1'b0;
		win_we    = 1'b0;
		win_wdata = '0;
		win_waddr = next_slot_q;
		unique case (state_q)
			ST_ENQ: begin
				pend_we = enq_ok;
				if (!enq_ok) begin
					emit_fire      = 1'b1;
					emit_word.kind = KIND_REFUSED;
					emit_word.size = cmd_q.size;
				end
			end
			ST_TCHK: begin
				if (expired && n_q < RES_W'(MAX_RESULTS) && emit_ok) begin
					emit_fire      = 1'b1;
					emit_word.kind = KIND_RESEND;
					emit_word.seq  = base_q + 16'(i_q);
					emit_word.size = win_rd_q[42:32];
					win_we         = 1'b1;
					win_waddr      = scan_slot_q;
					win_wdata      = {win_rd_q[42:32], cmd_q.now};
				end
			end
			ST_SEMIT: begin
				if (emit_ok) begin
					emit_fire      = 1'b1;
					emit_word.kind = KIND_NEW;
					emit_word.seq  = next_q;
					emit_word.size = pend_rd_q;
					win_we         = 1'b1;
					win_wdata      = {pend_rd_q, cmd_q.now};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_word      = hold_q;
		res_word.last = (state_q == ST_DONE);
		res_push      = hold_valid_q && ((emit_fire) || (state_q == ST_DONE && !res_full));
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[tail_q] <= cmd_q.size;
		end
		pend_rd_q <= pend_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= win_wdata;
		end
		win_rd_q <= win_mem[scan_slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (emit_fire) begin
			hold_q <= emit_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_q       <= '0;
			next_q       <= '0;
			base_slot_q  <= '0;
			next_slot_q  <= '0;
			scan_slot_q  <= '0;
			valid_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			i_q          <= '0;
			n_q          <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				hold_valid_q <= 1'b1;
				n_q          <= n_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						n_q         <= '0;
						i_q         <= '0;
						scan_slot_q <= base_slot_q;
						unique case (cmd.mode)
							MODE_ENQ:  state_q <= ST_ENQ;
							MODE_ACK:  state_q <= ST_ACK;
							MODE_TICK: state_q <= ST_TRD;
							default:   state_q <= ST_SRD;
						endcase
					end
				end
				ST_ENQ: begin
					if (enq_ok) begin
						tail_q  <= (tail_q == QW'(QUEUE_DEPTH-1)) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_SRD;
				end
				ST_ACK: begin
					if (d_ack < span) begin
						valid_q[ack_slot] <= 1'b0;
					end
					state_q <= ST_ASCAN;
				end
				ST_ASCAN: begin
					if (!scan_more) begin
						base_q      <= next_q;
						base_slot_q <= next_slot_q;
						state_q     <= ST_SRD;
					end else if (valid_q[scan_slot_q]) begin
						base_q      <= base_q + 16'(i_q);
						base_slot_q <= scan_slot_q;
						state_q     <= ST_SRD;
					end else begin
						i_q         <= i_q + 1'b1;
						scan_slot_q <= scan_inc;
					end
				end
				ST_TRD: begin
					state_q <= scan_more ? ST_TCHK : ST_SRD;
				end
				ST_TCHK: begin
					if (expired && n_q >= RES_W'(MAX_RESULTS)) begin
						state_q <= ST_DONE;
					end else if (!expired || emit_ok) begin
						i_q         <= i_q + 1'b1;
						scan_slot_q <= scan_inc;
						state_q     <= ST_TRD;
					end
				end
				ST_SRD: begin
					state_q <= send_ok ? ST_SEMIT : ST_DONE;
				end
				ST_SEMIT: begin
					if (emit_ok) begin
						valid_q[next_slot_q] <= 1'b1;
						next_q      <= next_q + 1'b1;
						next_slot_q <= next_inc;
						head_q      <= (head_q == QW'(QUEUE_DEPTH-1)) ? '0 : head_q + 1'b1;
						count_q     <= count_q - 1'b1;
						state_q     <= ST_SRD;
					end
				end
				ST_DONE: begin
					if (!hold_valid_q) begin
						state_q <= ST_IDLE;
					end else if (!res_full) begin
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) n_q <= RES_W'(MAX_RESULTS))
		else $error("result budget exceeded");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(QUEUE_DEPTH))
		else $error("pending count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) span <= 16'(WINDOW))
		else $error("outstanding span beyond window");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_valid_q)
		else $error("held result left over between items");

endmodule

### src/selective_repeat_send_window.sv
// Top level of the selective-repeat send window: config registers and wiring.
//
// channel  direction  handshake            words
// input    in         push / full          mode, seg_size, ack_seq, now_ms
// result   out        empty / pop          kind, seq, payload_size, last
// config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// In the back end, the resend scan reads each outstanding entry's stamp
// through the registered stamp memory read, and each new send waits on the
// registered pending memory read.
// A two-word command queue keeps input taken while the back end works.
// Reset clears all control state; memories come up undefined.
// A full result queue stalls the back end in place.
module selective_repeat_send_window #(
	parameter int WINDOW      = srsw_pkg::WINDOW_DEF,
	parameter int QUEUE_DEPTH = srsw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [10:0] seg_size,
	input  logic [15:0] ack_seq,
	input  logic [31:0] now_ms,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [15:0] seq,
	output logic [10:0] payload_size,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import srsw_pkg::*;

	cfg_t   cfg_q;
	cmd_t   cmd;
	res_t   res_in, res_out;
	logic   cmd_empty, cmd_pop, res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= 5'd16;
			cfg_q.queue_limit <= 7'd63;
			cfg_q.timeout_ms  <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE: cfg_q.window_size <= cfg_data[4:0];
				REG_QUEUE_LIMIT: cfg_q.queue_limit <= cfg_data[6:0];
				REG_TIMEOUT_MS:  cfg_q.timeout_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	srsw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.seg_size  (seg_size),
		.ack_seq   (ack_seq),
		.now_ms    (now_ms),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	srsw_engine #(
		.WINDOW      (WINDOW),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.cmd            (cmd),
		.res_push       (res_push),
		.res_word       (res_in),
		.res_full       (res_full)
	);

	srsw_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign kind         = res_out.kind;
	assign seq          = res_out.seq;
	assign payload_size = res_out.size;
	assign last         = res_out.last;

endmodule

### test/selective_repeat_send_window_tb.sv
// Testbench of the selective-repeat send window: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module selective_repeat_send_window_tb;
	import srsw_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam int QD  = QUEUE_DEPTH_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  mode = 2'd0;
	logic [10:0] seg_size = 11'd0;
	logic [15:0] ack_seq = 16'd0;
	logic [31:0] now_ms = 32'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [15:0] seq;
	logic [10:0] payload_size;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;

	selective_repeat_send_window dut (.*);

	// predictor state
	logic [4:0]  win_size_r;
	logic [6:0]  qlimit_r;
	logic [15:0] tmo_r;
	logic [10:0] pend_sizes [QD];
	int unsigned pend_cnt, pend_head;
	logic        out_valid [WIN];
	logic [10:0] out_size [WIN];
	logic [31:0] out_stamp [WIN];
	logic [15:0] base_seq, seq_next;

	res_t tx_expected [$];
	int   errors = 0;
	int   send_idle_pct = 0;
	int   pop_stall_pct = 0;
	logic [31:0] clock_ms = 32'd0;

	initial forever #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic predict_word(input logic [1:0] m, input logic [10:0] sz_in,
			input logic [15:0] ack, input logic [31:0] now);
		int unsigned w, span, n;
		logic [10:0] sz;
		logic [15:0] q, nb;
		int unsigned sl;
		res_t r;
		w = (win_size_r < WIN) ? win_size_r : WIN;
		n = 0;
		sz = (sz_in > MAX_PAYLOAD) ? 11'(MAX_PAYLOAD) : sz_in;
		span = 16'(seq_next - base_seq);
		if (m == MODE_ENQ) begin
			if (pend_cnt <= qlimit_r && pend_cnt < QD) begin
				pend_sizes[(pend_head + pend_cnt) % QD] = sz;
				pend_cnt++;
			end else begin
				r = '{kind: KIND_REFUSED, seq: 16'd0, size: sz, last: 1'b0};
				tx_expected.push_back(r);
				n++;
			end
		end else if (m == MODE_ACK) begin
			if (16'(ack - base_seq) < span)
				out_valid[ack % WIN] = 1'b0;
			nb = seq_next;
			for (int i = 0; i < span; i++) begin
				q = 16'(base_seq + i);
				if (out_valid[q % WIN]) begin
					nb = q;
					break;
				end
			end
			base_seq = nb;
		end else if (m == MODE_TICK) begin
			for (int i = 0; i < span; i++) begin
				q = 16'(base_seq + i);
				sl = q % WIN;
				if (out_valid[sl] && 32'(now - out_stamp[sl]) > tmo_r) begin
					if (n >= MAX_RESULTS)
						break;
					out_stamp[sl] = now;
					r = '{kind: KIND_RESEND, seq: q, size: out_size[sl], last: 1'b0};
					tx_expected.push_back(r);
					n++;
				end
			end
		end
		while (16'(seq_next - base_seq) < w && pend_cnt > 0 && n < MAX_RESULTS) begin
			sl = seq_next % WIN;
			out_valid[sl] = 1'b1;
			out_size[sl] = pend_sizes[pend_head];
			out_stamp[sl] = now;
			r = '{kind: KIND_NEW, seq: seq_next, size: pend_sizes[pend_head], last: 1'b0};
			tx_expected.push_back(r);
			pend_head = (pend_head + 1) % QD;
			pend_cnt--;
			seq_next = 16'(seq_next + 1);
			n++;
		end
		if (n > 0)
			tx_expected[$].last = 1'b1;
	endtask

	task automatic send_word(input logic [1:0] m, input logic [10:0] sz,
			input logic [15:0] ack, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		mode <= m;
		seg_size <= sz;
		ack_seq <= ack;
		now_ms <= now;
		predict_word(m, sz, ack, now);
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		push <= 1'b0;
		while (tx_expected.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WINDOW_SIZE: win_size_r = val[4:0];
			REG_QUEUE_LIMIT: qlimit_r = val[6:0];
			REG_TIMEOUT_MS:  tmo_r = val;
			default: ;
		endcase
	endtask

	// checker
	always @(posedge clk) begin
		res_t e;
		if (pop && !empty) begin
			if (tx_expected.size() == 0) begin
				$error("unexpected word kind=%0d seq=%0d", kind, seq);
				errors++;
			end else begin
				e = tx_expected.pop_front();
				if (kind !== e.kind) begin
					$error("kind expected %0d actual %0d", e.kind, kind);
					errors++;
				end
				if (seq !== e.seq) begin
					$error("seq expected %0d actual %0d", e.seq, seq);
					errors++;
				end
				if (payload_size !== e.size) begin
					$error("payload_size expected %0d actual %0d", e.size, payload_size);
					errors++;
				end
				if (last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, last);
					errors++;
				end
			end
		end
	end

	always @(negedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	task automatic test_directed();
		send_word(MODE_ENQ, 11'd0, 16'd0, 32'd0);
		send_word(MODE_ENQ, 11'd1024, 16'd0, 32'd0);
		send_word(MODE_ENQ, 11'h7FF, 16'd0, 32'd1);
		send_word(MODE_TICK, 11'd0, 16'd0, 32'd100);
		send_word(MODE_TICK, 11'd0, 16'd0, 32'd101);
		send_word(MODE_ACK, 11'd0, 16'd1, 32'd101);
		send_word(MODE_ACK, 11'd0, 16'hFFFF, 32'd101);
		send_word(MODE_ACK, 11'd0, 16'd0, 32'd101);
		send_word(MODE_NOP, 11'h7FF, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(MODE_TICK, 11'd0, 16'd0, 32'hFFFF_FFFF);
		send_word(MODE_ACK, 11'd0, 16'd2, 32'hFFFF_FFFF);
		write_reg(REG_QUEUE_LIMIT, 16'd0);
		write_reg(REG_WINDOW_SIZE, 16'd0);
		send_word(MODE_ENQ, 11'd5, 16'd0, 32'd3);
		send_word(MODE_ENQ, 11'd6, 16'd0, 32'd3);
		write_reg(REG_WINDOW_SIZE, 16'd31);
		send_word(MODE_NOP, 11'd0, 16'd0, 32'd4);
		send_word(MODE_ACK, 11'd0, 16'd3, 32'd4);
		write_reg(REG_QUEUE_LIMIT, 16'd64);
		write_reg(REG_TIMEOUT_MS, 16'd1);
		// fill the window so the tick resends every outstanding entry
		for (int i = 0; i < 40; i++)
			send_word(MODE_ENQ, 11'($urandom_range(1024)), 16'd0, 32'd10);
		send_word(MODE_TICK, 11'd0, 16'd0, 32'd20);
		write_reg(REG_TIMEOUT_MS, 16'hFFFF);
		send_word(MODE_TICK, 11'd0, 16'd0, 32'd20);
	endtask

	task automatic test_random(input int count);
		logic [1:0]  m;
		logic [15:0] a;
		int unsigned p;
		for (int i = 0; i < count; i++) begin
			clock_ms = clock_ms + $urandom_range(60);
			p = $urandom_range(99);
			if (p < 45) m = MODE_ENQ;
			else if (p < 75) m = MODE_ACK;
			else if (p < 95) m = MODE_TICK;
			else m = MODE_NOP;
			if ($urandom_range(9) < 7 && seq_next != base_seq)
				a = 16'(base_seq + $urandom_range(16'(seq_next - base_seq) - 1));
			else
				a = 16'($urandom);
			send_word(m, ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1024)),
				a, ($urandom_range(19) == 0) ? $urandom : clock_ms);
		end
	endtask

	task automatic test_phase(input int sidle, input int pstall, input int count);
		send_idle_pct = sidle;
		pop_stall_pct = pstall;
		test_random(count);
	endtask

	initial begin
		win_size_r = 5'd16;
		qlimit_r = 7'd63;
		tmo_r = 16'd100;
		pend_cnt = 0;
		pend_head = 0;
		base_seq = 16'd0;
		seq_next = 16'd0;
		for (int i = 0; i < WIN; i++)
			out_valid[i] = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		write_reg(REG_WINDOW_SIZE, 16'd4);
		write_reg(REG_TIMEOUT_MS, 16'd50);
		write_reg(REG_QUEUE_LIMIT, 16'd8);
		test_phase(0, 0, 40);
		write_reg(REG_WINDOW_SIZE, 16'd1);
		test_phase(69, 0, 36);
		write_reg(REG_WINDOW_SIZE, 16'd16);
		write_reg(REG_TIMEOUT_MS, 16'd20);
		write_reg(REG_QUEUE_LIMIT, 16'd63);
		test_phase(0, 69, 40);
		write_reg(REG_TIMEOUT_MS, 16'd100);
		test_phase(38, 38, 37);
		drain();
		if (errors == 0 && tx_expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
